### src/h3sp_pkg.sv
package h3sp_pkg;

  // parser phases
  localparam logic [1:0] PH_ID    = 2'd0;
  localparam logic [1:0] PH_VALUE = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;
  localparam logic [1:0] PH_ERROR = 2'd3;

  // result status codes
  localparam logic [1:0] ST_NEED  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_LENGTH  = 2'd1;
  localparam logic [1:0] ERR_SETTING = 2'd2;

  // word function selector
  localparam logic FN_START = 1'b0;
  localparam logic FN_BYTE  = 1'b1;

  // known setting identifiers
  localparam logic [61:0] ID_CAPACITY = 62'h01;
  localparam logic [61:0] ID_SECTION  = 62'h06;
  localparam logic [61:0] ID_BLOCKED  = 62'h07;
  localparam logic [61:0] ID_CONNECT  = 62'h08;

  localparam int unsigned VAL_W = 62;

  // seen mask bit positions
  localparam int unsigned SEEN_CAPACITY = 0;
  localparam int unsigned SEEN_BLOCKED  = 1;
  localparam int unsigned SEEN_SECTION  = 2;
  localparam int unsigned SEEN_CONNECT  = 3;

  typedef struct packed {
    logic [1:0]       phase;
    logic [VAL_W-1:0] bytes_left;
    logic [VAL_W-1:0] pending_id;
    logic [VAL_W-1:0] accumulator;
    logic [3:0]       int_length;
    logic [3:0]       int_count;
    logic             int_active;
    logic [VAL_W-1:0] capacity;
    logic [VAL_W-1:0] blocked;
    logic [VAL_W-1:0] section;
    logic             connect;
    logic [3:0]       seen;
    logic [1:0]       last_error;
  } h3sp_state_t;

  // state after reset: everything clear, parser in the done phase
  function automatic h3sp_state_t reset_state();
    h3sp_state_t s;
    s       = '0;
    s.phase = PH_DONE;
    return s;
  endfunction

endpackage

### src/h3sp_step.sv
module h3sp_step
  import h3sp_pkg::*;
(
  input  h3sp_state_t      state_i,
  input  logic             func_i,
  input  logic [VAL_W-1:0] frame_len_i,
  input  logic [7:0]       data_byte_i,
  output h3sp_state_t      state_o,
  output logic [1:0]       status_o
);

  h3sp_state_t      nxt;
  logic [1:0]       status;
  logic [1:0]       err;
  logic             complete;
  logic [VAL_W-1:0] bl1;
  logic [3:0]       len;
  logic [3:0]       cnt;
  logic [VAL_W-1:0] acc;

  assign bl1 = state_i.bytes_left - VAL_W'(1);

  // next state for one word
  always_comb begin
    nxt      = state_i;
    status   = ST_NEED;
    err      = ERR_NONE;
    complete = 1'b0;
    len      = state_i.int_length;
    cnt      = state_i.int_count;
    acc      = state_i.accumulator;

    if (func_i == FN_START) begin
      nxt            = '0;
      nxt.bytes_left = frame_len_i;
      if (frame_len_i == '0) begin
        nxt.phase = PH_DONE;
        status    = ST_DONE;
      end else begin
        nxt.phase = PH_ID;
      end
    end else begin
      case (state_i.phase)
        PH_DONE:  status = ST_DONE;
        PH_ERROR: status = ST_ERROR;
        default: begin
          if (state_i.bytes_left == '0) begin
            err = ERR_LENGTH;
          end else begin
            nxt.bytes_left = bl1;
            if (!state_i.int_active) begin
              // first byte: prefix gives 1, 2, 4 or 8 bytes
              len            = 4'd1 << data_byte_i[7:6];
              nxt.int_length = len;
              if (bl1 < {58'd0, len - 4'd1}) begin
                err = ERR_LENGTH;
              end else begin
                acc      = {56'd0, data_byte_i[5:0]};
                cnt      = 4'd1;
                complete = (data_byte_i[7:6] == 2'd0);
              end
            end else begin
              acc      = {state_i.accumulator[VAL_W-9:0], data_byte_i};
              cnt      = state_i.int_count + 4'd1;
              complete = (cnt >= state_i.int_length);
            end

            if (err == ERR_NONE) begin
              nxt.accumulator = acc;
              nxt.int_count   = cnt;
              nxt.int_active  = 1'b1;
              if (complete) begin
                nxt.int_active  = 1'b0;
                nxt.int_count   = 4'd0;
                nxt.int_length  = 4'd0;
                nxt.accumulator = '0;
                if (state_i.phase == PH_ID) begin
                  nxt.pending_id = acc;
                  nxt.phase      = PH_VALUE;
                  if (bl1 == '0) err = ERR_LENGTH;
                end else begin
                  // store a known setting, reject repeats and connect values above one
                  if (state_i.pending_id == ID_CAPACITY) begin
                    if (state_i.seen[SEEN_CAPACITY]) err = ERR_SETTING;
                    else begin
                      nxt.seen[SEEN_CAPACITY] = 1'b1;
                      nxt.capacity            = acc;
                    end
                  end else if (state_i.pending_id == ID_BLOCKED) begin
                    if (state_i.seen[SEEN_BLOCKED]) err = ERR_SETTING;
                    else begin
                      nxt.seen[SEEN_BLOCKED] = 1'b1;
                      nxt.blocked            = acc;
                    end
                  end else if (state_i.pending_id == ID_SECTION) begin
                    if (state_i.seen[SEEN_SECTION]) err = ERR_SETTING;
                    else begin
                      nxt.seen[SEEN_SECTION] = 1'b1;
                      nxt.section            = acc;
                    end
                  end else if (state_i.pending_id == ID_CONNECT) begin
                    if (state_i.seen[SEEN_CONNECT] || (acc[VAL_W-1:1] != '0)) begin
                      err = ERR_SETTING;
                    end else begin
                      nxt.seen[SEEN_CONNECT] = 1'b1;
                      nxt.connect            = acc[0];
                    end
                  end
                  if (err == ERR_NONE) begin
                    if (bl1 == '0) begin
                      nxt.phase = PH_DONE;
                      status    = ST_DONE;
                    end else begin
                      nxt.phase = PH_ID;
                    end
                  end
                end
              end
            end
          end

          // sticky error until the next start
          if (err != ERR_NONE) begin
            nxt.phase      = PH_ERROR;
            nxt.last_error = err;
            status         = ST_ERROR;
          end
        end
      endcase
    end
  end

  assign state_o  = nxt;
  assign status_o = status;

endmodule

### src/http3_settings_frame_parser_unit.sv
// HTTP/3 SETTINGS frame payload parser.
// Input stream: tuser selects the word kind (0 start of a payload, 1 payload
// byte). A start word carries the payload length in tdata and clears all
// stored settings, seen marks and the error; a byte word carries one payload
// byte. Every input word gives exactly one result word on the output stream:
// status, error code, the three stored 62-bit settings, the connect flag and
// the seen mask, as they stand after that word.
// A word taken into the input register has its result written by the decode
// logic into the result register as soon as that register is free (input
// register, then result register).
// Throughput is one word per cycle unless the receiver stalls; the whole
// per-byte decode (shift, compare, decrement) sits between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more word; after that s_axis_tready drops until the result
// is taken. Reset empties both registers and leaves the parser in the done
// phase, so bytes before the first start are ignored with status done.
module http3_settings_frame_parser_unit
  import h3sp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [61:0] frame_len, [69:62] data_byte, [71:70] zero
  input  logic [71:0]  s_axis_tdata,
  // [0] func
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] status, [3:2] error_code, [65:4] table_capacity,
  // [127:66] blocked_streams, [189:128] field_section_limit,
  // [190] connect_enabled, [194:191] seen_mask, [199:195] zero
  output logic [199:0] m_axis_tdata
);

  logic             in_valid_q;
  logic             in_func_q;
  logic [VAL_W-1:0] in_len_q;
  logic [7:0]       in_byte_q;
  logic             out_valid_q;
  logic [199:0]     out_data_q;
  h3sp_state_t      state_q;
  h3sp_state_t      state_d;
  logic [1:0]       status;
  logic [1:0]       err_out;
  logic             proc_fire;
  logic             in_fire;

  assign proc_fire     = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_func_q <= s_axis_tuser;
      in_len_q  <= s_axis_tdata[VAL_W-1:0];
      in_byte_q <= s_axis_tdata[69:62];
    end
  end

  // per-word decode
  h3sp_step u_step (
    .state_i     (state_q),
    .func_i      (in_func_q),
    .frame_len_i (in_len_q),
    .data_byte_i (in_byte_q),
    .state_o     (state_d),
    .status_o    (status)
  );

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= reset_state();
    end else if (proc_fire) begin
      state_q <= state_d;
    end
  end

  assign err_out = (status == ST_ERROR) ? state_d.last_error : ERR_NONE;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      out_data_q <= {5'd0, state_d.seen, state_d.connect, state_d.section,
                     state_d.blocked, state_d.capacity, err_out, status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_err_code_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_data_q[1:0] == ST_ERROR) == (out_data_q[3:2] != ERR_NONE)))
    else $error("error code does not match status");

  a_error_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_ERROR) |-> (state_q.last_error != ERR_NONE))
    else $error("error phase without error code");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.int_active |-> (state_q.int_count < state_q.int_length))
    else $error("integer byte count beyond its length");

  a_connect_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.connect |-> state_q.seen[SEEN_CONNECT])
    else $error("connect flag set without seen mark");

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc_fire |=> $stable(state_q))
    else $error("parser state changed without a word");
`endif

endmodule

### bench/settings_check_pkg.sv
`timescale 1ns / 1ps
package settings_check_pkg;
  import h3sp_pkg::*;

  // one result word, unpacked
  typedef struct {
    logic [1:0]       status;
    logic [1:0]       err;
    logic [VAL_W-1:0] capacity;
    logic [VAL_W-1:0] blocked;
    logic [VAL_W-1:0] section;
    logic             connect;
    logic [3:0]       seen;
  } settings_report_t;

  class settings_scoreboard;
    // predicted parser state
    logic [1:0]       phase;
    logic [VAL_W-1:0] bytes_left;
    logic [VAL_W-1:0] pending_id;
    logic [VAL_W-1:0] acc;
    int unsigned      int_len;
    int unsigned      int_cnt;
    bit               int_busy;
    logic [VAL_W-1:0] capacity;
    logic [VAL_W-1:0] blocked;
    logic [VAL_W-1:0] section;
    logic             connect;
    logic [3:0]       seen;
    logic [1:0]       last_err;
    // reports still owed by the block, oldest first
    settings_report_t reports_q[$];
    int unsigned      fails;

    function new();
      clear_frame();
      fails = 0;
    endfunction

    function void clear_frame();
      phase      = PH_DONE;
      bytes_left = '0;
      pending_id = '0;
      acc        = '0;
      int_len    = 0;
      int_cnt    = 0;
      int_busy   = 1'b0;
      capacity   = '0;
      blocked    = '0;
      section    = '0;
      connect    = 1'b0;
      seen       = '0;
      last_err   = ERR_NONE;
    endfunction

    function logic [1:0] fail_with(logic [1:0] code);
      last_err = code;
      phase    = PH_ERROR;
      return ST_ERROR;
    endfunction

    // store a known setting, rejecting repeats and bad connect values
    function logic [1:0] store_setting(logic [VAL_W-1:0] id, logic [VAL_W-1:0] val);
      case (id)
        ID_CAPACITY: begin
          if (seen[SEEN_CAPACITY]) return fail_with(ERR_SETTING);
          seen[SEEN_CAPACITY] = 1'b1;
          capacity = val;
        end
        ID_BLOCKED: begin
          if (seen[SEEN_BLOCKED]) return fail_with(ERR_SETTING);
          seen[SEEN_BLOCKED] = 1'b1;
          blocked = val;
        end
        ID_SECTION: begin
          if (seen[SEEN_SECTION]) return fail_with(ERR_SETTING);
          seen[SEEN_SECTION] = 1'b1;
          section = val;
        end
        ID_CONNECT: begin
          if (seen[SEEN_CONNECT] || val > 1) return fail_with(ERR_SETTING);
          seen[SEEN_CONNECT] = 1'b1;
          connect = val[0];
        end
        default: ;
      endcase
      return ST_NEED;
    endfunction

    // varint decode of one payload byte
    function logic [1:0] parse_byte(logic [7:0] b);
      bit               complete;
      logic [VAL_W-1:0] val;
      logic [1:0]       st;
      if (phase == PH_DONE) return ST_DONE;
      if (phase == PH_ERROR) return ST_ERROR;
      if (bytes_left == 0) return fail_with(ERR_LENGTH);
      bytes_left = bytes_left - 1;
      if (!int_busy) begin
        int_len = 32'd1 << b[7:6];
        if (bytes_left < int_len - 1) return fail_with(ERR_LENGTH);
        acc      = {{(VAL_W-6){1'b0}}, b[5:0]};
        int_cnt  = 1;
        int_busy = 1'b1;
        complete = (int_len == 1);
      end else begin
        acc      = {acc[VAL_W-9:0], b};
        int_cnt  = int_cnt + 1;
        complete = (int_cnt >= int_len);
      end
      if (!complete) return ST_NEED;

      int_busy = 1'b0;
      int_cnt  = 0;
      int_len  = 0;
      // identifier finished: a value must follow
      if (phase == PH_ID) begin
        pending_id = acc;
        acc        = '0;
        phase      = PH_VALUE;
        if (bytes_left == 0) return fail_with(ERR_LENGTH);
        return ST_NEED;
      end
      val = acc;
      acc = '0;
      st  = store_setting(pending_id, val);
      if (st == ST_ERROR) return st;
      if (bytes_left == 0) begin
        phase = PH_DONE;
        return ST_DONE;
      end
      phase = PH_ID;
      return ST_NEED;
    endfunction

    // accepted input word: predict its report
    function void note_word(logic fn, logic [VAL_W-1:0] len, logic [7:0] b);
      settings_report_t r;
      if (fn == FN_START) begin
        clear_frame();
        bytes_left = len;
        phase      = (len == 0) ? PH_DONE : PH_ID;
        r.status   = (len == 0) ? ST_DONE : ST_NEED;
      end else begin
        r.status = parse_byte(b);
      end
      r.err      = (r.status == ST_ERROR) ? last_err : ERR_NONE;
      r.capacity = capacity;
      r.blocked  = blocked;
      r.section  = section;
      r.connect  = connect;
      r.seen     = seen;
      reports_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        fails++;
      end
    endfunction

    // accepted result word: compare with the oldest prediction
    function void check_result(logic [199:0] d);
      settings_report_t r;
      if (reports_q.size() == 0) begin
        $display("%0t: result expected none, got 0x%0h", $time, d);
        fails++;
        return;
      end
      r = reports_q.pop_front();
      compare_field("status", VAL_W'(r.status), VAL_W'(d[1:0]));
      compare_field("error_code", VAL_W'(r.err), VAL_W'(d[3:2]));
      compare_field("table_capacity", r.capacity, d[65:4]);
      compare_field("blocked_streams", r.blocked, d[127:66]);
      compare_field("field_section_limit", r.section, d[189:128]);
      compare_field("connect_enabled", VAL_W'(r.connect), VAL_W'(d[190]));
      compare_field("seen_mask", VAL_W'(r.seen), VAL_W'(d[194:191]));
      compare_field("padding", '0, VAL_W'(d[199:195]));
    endfunction
  endclass

endpackage

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import h3sp_pkg::*;
  import settings_check_pkg::*;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // [61:0] frame_len, [69:62] data_byte, [71:70] zero
  logic [71:0]  s_axis_tdata  = '0;
  // [0] func
  logic         s_axis_tuser  = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [1:0] status, [3:2] error_code, [65:4] table_capacity,
  // [127:66] blocked_streams, [189:128] field_section_limit,
  // [190] connect_enabled, [194:191] seen_mask, [199:195] zero
  logic [199:0] m_axis_tdata;

  settings_scoreboard sb;
  int unsigned        burst_left = 0;
  int unsigned        rx_cycle   = 0;
  int unsigned        words_sent = 0;
  logic [7:0]         payload_q[$];

  http3_settings_frame_parser_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // receiver stall pattern, cycling through four characters
  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle >> 8) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(1));
      2: m_axis_tready <= ($urandom_range(4) == 0);
      default: m_axis_tready <= ((rx_cycle % 7) < 3);
    endcase
  end

  // note accepted words and check results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_word(s_axis_tuser, s_axis_tdata[61:0], s_axis_tdata[69:62]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata);
    end
  end

  function automatic logic [VAL_W-1:0] rand62();
    return VAL_W'({$urandom, $urandom});
  endfunction

  // drive one word, with bursty gaps, and wait for its acceptance
  task automatic send_word(input logic fn, input logic [VAL_W-1:0] len, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(3) == 0) begin
        burst_left = $urandom_range(60, 30);
        gap        = 0;
      end else begin
        burst_left = $urandom_range(12, 1);
        gap        = $urandom_range(8, 1);
      end
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {2'b00, b, len};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // unused fields carry random bits
  task automatic send_start(input logic [VAL_W-1:0] len);
    send_word(FN_START, len, 8'($urandom_range(255)));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(FN_BYTE, rand62(), b);
  endtask

  // append a varint of 1, 2, 4 or 8 bytes (code 0..3)
  task automatic append_varint(input logic [VAL_W-1:0] v, input int unsigned code);
    int unsigned nbytes;
    logic [63:0] w;
    nbytes = 1 << code;
    w      = {2'b00, v};
    if (nbytes < 8) w = w & ((64'h1 << (8 * nbytes - 2)) - 1);
    w = w | (64'(code) << (8 * nbytes - 2));
    for (int k = int'(nbytes) - 1; k >= 0; k--) payload_q.push_back(w[8*k +: 8]);
  endtask

  function automatic int unsigned rand_code();
    return ($urandom_range(2) == 0) ? $urandom_range(3) : 0;
  endfunction

  // one random frame: mostly well formed, sometimes truncated, padded or corrupted
  task automatic random_frame();
    int unsigned      nsettings;
    int unsigned      variant;
    logic [VAL_W-1:0] id;
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] len;
    payload_q.delete();
    nsettings = $urandom_range(4);
    repeat (nsettings) begin
      case ($urandom_range(4))
        0: id = ID_CAPACITY;
        1: id = ID_BLOCKED;
        2: id = ID_SECTION;
        3: id = ID_CONNECT;
        default: id = rand62();
      endcase
      append_varint(id, (id <= ID_CONNECT) ? rand_code() : $urandom_range(3));
      case ($urandom_range(5))
        0: val = '1;
        1, 2: val = VAL_W'($urandom_range(3));
        default: val = rand62();
      endcase
      if (id == ID_CONNECT && $urandom_range(3) != 0) val = VAL_W'($urandom_range(1));
      append_varint(val, $urandom_range(3));
    end
    len     = VAL_W'(payload_q.size());
    variant = $urandom_range(9);
    if (variant == 0) len = VAL_W'($urandom_range(payload_q.size()));
    else if (variant == 1)
      len = ($urandom_range(3) == 0) ? rand62() : len + VAL_W'($urandom_range(3, 1));
    else if (variant == 2 && payload_q.size() > 0)
      payload_q[$urandom_range(payload_q.size() - 1)] = 8'($urandom_range(255));
    send_start(len);
    foreach (payload_q[i]) send_byte(payload_q[i]);
    words_sent += 1 + payload_q.size();
    // stray bytes after the frame
    if ($urandom_range(7) == 0) repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)));
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // byte before any start is ignored
    send_byte(8'hA5);
    // empty payload finishes at once
    send_start('0);
    // largest length, largest capacity, then a repeated capacity
    send_start('1);
    send_byte(8'h01);
    repeat (8) send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h00);
    // byte while in error
    send_byte(8'h5A);
    // connect value above one
    send_start(62'd2);
    send_byte(8'h08);
    send_byte(8'h02);
    // identifier uses up the payload
    send_start(62'd1);
    send_byte(8'h06);
    // two-byte integer with one byte left
    send_start(62'd1);
    send_byte(8'h40);
    // unknown identifier skipped, payload ends on a value, then a byte while done
    send_start(62'd4);
    send_byte(8'h21);
    send_byte(8'h00);
    send_byte(8'h07);
    send_byte(8'h05);
    send_byte(8'h33);

    while (words_sent < 1000) random_frame();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.reports_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.fails == 0 && sb.reports_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
